// ===== design/ccrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccrf_pkg
// Shared types, constants and address decode for the clock control
// register file.
// ----------------------------------------------------------------------------
package ccrf_pkg;

    // Store geometry
    localparam int REG_WORDS = 16384;
    localparam int MEM_AW    = $clog2(REG_WORDS);
    localparam int WA_W      = 14;
    localparam int DATA_W    = 32;

    // Access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Window limits, byte offsets (end is exclusive)
    localparam logic [15:0] ROOT_END   = 16'h2f80;
    localparam logic [15:0] GPR0_FIRST = 16'h4800;
    localparam logic [15:0] GPR0_END   = 16'h4a00;
    localparam logic [15:0] GPR1_FIRST = 16'h4c00;
    localparam logic [15:0] GPR1_END   = 16'h4e00;
    localparam logic [15:0] GATE0_FIRST = 16'h5000;
    localparam logic [15:0] GATE0_END   = 16'h5500;
    localparam logic [15:0] GATE1_FIRST = 16'h8000;
    localparam logic [15:0] GATE1_END   = 16'h9fc0;

    // Offsets inside a block
    localparam logic [6:0] OFS_ALIAS_LAST = 7'h0c;
    localparam logic [6:0] OFS_GATE_LPCUR = 7'h1c;
    localparam logic [6:0] OFS_STATUS0    = 7'h20;
    localparam logic [6:0] OFS_STATUS1    = 7'h24;
    localparam logic [6:0] OFS_AUTH_FIRST = 7'h30;
    localparam logic [6:0] OFS_AUTH_LAST  = 7'h3c;

    // Fixed read values
    localparam logic [DATA_W-1:0] AUTHEN_VALUE  = (32'h1 << 9) | (32'hffff << 16);
    localparam logic [DATA_W-1:0] STATUS1_VALUE = 32'h0000_ffff;
    localparam logic [DATA_W-1:0] GATE_ON       = 32'h1;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ROOT,
        KIND_GPR,
        KIND_GATE
    } kind_t;

    // Alias write operations, selected by blk_ofs[3:2]
    typedef enum logic [1:0] {
        OP_PLAIN  = 2'd0,
        OP_SET    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_TOGGLE = 2'd3
    } alias_op_t;

    typedef enum logic [2:0] {
        RD_MEM,
        RD_ZERO,
        RD_BIT0,
        RD_STATUS1,
        RD_AUTHEN
    } rd_sel_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [6:0]         blk_ofs;
        logic               in_range;
        logic               alias_hit;
        logic               wr_ignore;
        rd_sel_t            rd_sel;
        logic [MEM_AW-1:0]  mem_idx;   // word touched by this transaction
    } dec_t;

    function automatic dec_t decode_addr(input logic [WA_W-1:0] wa);
        logic [15:0]       byte_off;
        logic [WA_W-1:0]   base;
        dec_t              d;
        logic              authen;
        byte_off    = {wa, 2'b00};
        base        = wa;
        d.kind      = KIND_NONE;
        d.blk_ofs   = '0;
        if (byte_off < ROOT_END) begin
            d.kind    = KIND_ROOT;
            d.blk_ofs = byte_off[6:0];
            base      = {wa[WA_W-1:5], 5'b0};
        end else if ((byte_off >= GPR0_FIRST && byte_off < GPR0_END) ||
                     (byte_off >= GPR1_FIRST && byte_off < GPR1_END)) begin
            d.kind    = KIND_GPR;
            d.blk_ofs = {1'b0, byte_off[5:0]};
            base      = {wa[WA_W-1:4], 4'b0};
        end else if ((byte_off >= GATE0_FIRST && byte_off < GATE0_END) ||
                     (byte_off >= GATE1_FIRST && byte_off < GATE1_END)) begin
            d.kind    = KIND_GATE;
            d.blk_ofs = {1'b0, byte_off[5:0]};
            base      = {wa[WA_W-1:4], 4'b0};
        end
        d.in_range  = (32'(wa) < 32'(REG_WORDS));
        authen      = (d.kind != KIND_NONE) &&
                      (d.blk_ofs >= OFS_AUTH_FIRST) && (d.blk_ofs <= OFS_AUTH_LAST);
        d.alias_hit = (d.kind == KIND_ROOT || d.kind == KIND_GPR) &&
                      (d.blk_ofs <= OFS_ALIAS_LAST);
        d.wr_ignore = !d.in_range || authen ||
                      (d.kind == KIND_ROOT && d.blk_ofs == OFS_STATUS0) ||
                      (d.kind == KIND_GATE &&
                       (d.blk_ofs == OFS_STATUS0 || d.blk_ofs == OFS_STATUS1 ||
                        d.blk_ofs == OFS_GATE_LPCUR));
        // Read source, in the same priority as the register map
        if (d.alias_hit)
            d.rd_sel = RD_MEM;
        else if (d.kind == KIND_ROOT && d.blk_ofs == OFS_STATUS0)
            d.rd_sel = RD_ZERO;
        else if (d.kind == KIND_GATE && d.blk_ofs == OFS_STATUS0)
            d.rd_sel = RD_BIT0;
        else if (d.kind == KIND_GATE && d.blk_ofs == OFS_STATUS1)
            d.rd_sel = RD_STATUS1;
        else if (authen)
            d.rd_sel = RD_AUTHEN;
        else
            d.rd_sel = RD_MEM;
        if (d.rd_sel == RD_MEM && !d.in_range)
            d.rd_sel = RD_ZERO;
        // Alias and gate status0 accesses go to the block's base word
        if (d.alias_hit || (d.kind == KIND_GATE && d.blk_ofs == OFS_STATUS0))
            d.mem_idx = MEM_AW'(base);
        else
            d.mem_idx = MEM_AW'(wa);
        return d;
    endfunction

    // Power-up contents: gate direct words are one, everything else zero
    function automatic logic [DATA_W-1:0] reset_word(input logic [MEM_AW-1:0] idx);
        dec_t d;
        d = decode_addr(WA_W'(idx));
        if ((32'(idx) < (32'(1) << WA_W)) && d.kind == KIND_GATE && d.blk_ofs == '0)
            return GATE_ON;
        return '0;
    endfunction

endpackage
`default_nettype wire

// ===== design/ccrf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccrf_req_if / ccrf_rsp_if
// Valid/ready channels for register access requests and read responses.
// ----------------------------------------------------------------------------
interface ccrf_req_if
    import ccrf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [WA_W-1:0]   word_address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output func, output word_address,
                    output write_data, input ready);
    modport sink   (input valid, input func, input word_address,
                    input write_data, output ready);
endinterface

interface ccrf_rsp_if
    import ccrf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface
`default_nettype wire

// ===== design/clock_control_register_file.sv =====
`default_nettype none
// Reads: the store word is read at acceptance, and the response register is
//   loaded in ST_EXEC once the response slot is free. Requests are taken only
//   in ST_IDLE, after the previous read, modify and write back is complete.
// Reset: after rst_n releases, a clearing pass writes the power-up value into
//   all REG_WORDS words before the first request is taken.
// ----------------------------------------------------------------------------
// clock_control_register_file
// Clock controller register file: decoded root, general-purpose and gate
// blocks with set/clear/toggle aliases, status and authentication words,
// held in one synchronous memory.
// ----------------------------------------------------------------------------
module clock_control_register_file
    import ccrf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ccrf_req_if.sink    req,
    ccrf_rsp_if.source  rsp
);

    // ------------------------------------------------------------------
    // Register store: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] mem [REG_WORDS];
    logic [DATA_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;

    // ------------------------------------------------------------------
    // Control and held transaction
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [MEM_AW-1:0] clr_idx_reg, clr_idx_next;
    logic              func_reg;
    dec_t              dec_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;

    dec_t              req_dec;
    logic              req_fire;
    logic [DATA_W-1:0] rd_value;
    logic [DATA_W-1:0] mod_value;

    assign req_dec  = decode_addr(req.word_address);
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire = req.valid && req.ready;
    assign mem_re   = req_fire;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

    // Memory read: issued at acceptance, data used in ST_EXEC
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[req_dec.mem_idx];
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg  <= req.func;
            dec_reg   <= req_dec;
            wdata_reg <= req.write_data;
        end
    end

    // Read response value
    always_comb
    begin
        unique case (dec_reg.rd_sel)
            RD_MEM:     rd_value = mem_rdata_reg;
            RD_ZERO:    rd_value = '0;
            RD_BIT0:    rd_value = mem_rdata_reg & GATE_ON;
            RD_STATUS1: rd_value = STATUS1_VALUE;
            RD_AUTHEN:  rd_value = AUTHEN_VALUE;
            default:    rd_value = '0;
        endcase
    end

    // Write value: alias ops modify the base word, others store plainly
    always_comb
    begin
        mod_value = wdata_reg;
        if (dec_reg.alias_hit)
        begin
            unique case (alias_op_t'(dec_reg.blk_ofs[3:2]))
                OP_PLAIN:  mod_value = wdata_reg;
                OP_SET:    mod_value = mem_rdata_reg | wdata_reg;
                OP_CLEAR:  mod_value = mem_rdata_reg & ~wdata_reg;
                OP_TOGGLE: mod_value = mem_rdata_reg ^ wdata_reg;
                default:   mod_value = wdata_reg;
            endcase
        end
    end

    // Next state, memory write and response register
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = dec_reg.mem_idx;
        mem_wdata      = mod_value;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep power-up values through the whole store
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = reset_word(clr_idx_reg);
                if (clr_idx_reg == MEM_AW'(REG_WORDS - 1))
                    state_next = ST_IDLE;
                else
                    clr_idx_next = clr_idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (req_fire)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (func_reg == FUNC_WRITE)
                begin
                    mem_we     = !dec_reg.wr_ignore;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || rsp.ready)
                begin
                    // response slot free: load it; stored read data holds
                    // while the slot is still occupied
                    out_valid_next = 1'b1;
                    out_data_next  = rd_value;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clock control register file. Register accesses
// are pushed through the request channel; an in-bench register image predicts
// each read response, and responses are checked in order.
// ----------------------------------------------------------------------------
module tb;
    import ccrf_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 283;     // per phase, three phases
    localparam int HOLD_CYCLES    = 300;     // long response back-pressure
    localparam int DRAIN_CYCLES   = 8;       // margin before the final check
    localparam int WATCHDOG_LIMIT = 60000;   // covers the clear pass over all REG_WORDS words
    localparam int REPORT_LIMIT   = 10;

    // Word-index bases of the decode windows
    localparam logic [WA_W-1:0] GPR0_WORD  = 14'h1200;
    localparam logic [WA_W-1:0] GPR1_WORD  = 14'h1300;
    localparam logic [WA_W-1:0] GATE0_WORD = 14'h1400;
    localparam logic [WA_W-1:0] GATE1_WORD = 14'h2000;
    localparam int ROOT_BLOCKS  = 95;
    localparam int GPR_BLOCKS   = 8;
    localparam int GATE0_BLOCKS = 20;
    localparam int GATE1_BLOCKS = 127;

    typedef struct packed {
        logic              func;
        logic [WA_W-1:0]   word_address;
        logic [DATA_W-1:0] write_data;
    } access_t;

    typedef struct packed {
        logic [WA_W-1:0]   word_address;
        logic [DATA_W-1:0] read_data;
    } read_expect_t;

    logic clk;
    logic rst_n;

    ccrf_req_if req_ch ();
    ccrf_rsp_if rsp_ch ();

    clock_control_register_file uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Bench-side image of the register store
    logic [DATA_W-1:0] reg_image [REG_WORDS];

    access_t      pending_items [$];
    read_expect_t pending_reads [$];

    int req_idle_pct;
    int rsp_idle_pct;
    int holds_asked;
    int holds_done;
    int hold_left;
    int mismatch_count;
    int idle_cycles;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Address decode and prediction
    // ------------------------------------------------------------------------

    // Classify a word index: window kind, byte offset inside its block and
    // the word index of the block's base.
    function automatic void split_address(input logic [WA_W-1:0] wa,
                                          output kind_t kind,
                                          output logic [6:0] blk_ofs,
                                          output logic [WA_W-1:0] base_wa);
        logic [15:0] byte_off;
        byte_off = {wa, 2'b00};
        kind     = KIND_NONE;
        blk_ofs  = '0;
        if (byte_off < ROOT_END)
        begin
            kind    = KIND_ROOT;
            blk_ofs = byte_off[6:0];
        end
        else if ((byte_off >= GPR0_FIRST && byte_off < GPR0_END) ||
                 (byte_off >= GPR1_FIRST && byte_off < GPR1_END))
        begin
            kind    = KIND_GPR;
            blk_ofs = {1'b0, byte_off[5:0]};
        end
        else if ((byte_off >= GATE0_FIRST && byte_off < GATE0_END) ||
                 (byte_off >= GATE1_FIRST && byte_off < GATE1_END))
        begin
            kind    = KIND_GATE;
            blk_ofs = {1'b0, byte_off[5:0]};
        end
        base_wa = wa - WA_W'(blk_ofs >> 2);
    endfunction

    // Power-up image: gate direct words one, all else zero
    function automatic void load_power_up_image();
        kind_t           kind;
        logic [6:0]      blk_ofs;
        logic [WA_W-1:0] base_wa;
        for (int i = 0; i < REG_WORDS; i++)
        begin
            split_address(WA_W'(i), kind, blk_ofs, base_wa);
            reg_image[i] = (kind == KIND_GATE && blk_ofs == '0) ? GATE_ON : '0;
        end
    endfunction

    // Apply one access to the image; a read returns the value the block owes.
    function automatic void apply_access(input access_t acc, output bit is_read,
                                         output logic [DATA_W-1:0] read_value);
        kind_t             kind;
        logic [6:0]        blk_ofs;
        logic [WA_W-1:0]   base_wa;
        logic              aliased;
        logic              authen;
        logic [DATA_W-1:0] word;
        split_address(acc.word_address, kind, blk_ofs, base_wa);
        aliased    = (kind == KIND_ROOT || kind == KIND_GPR) && blk_ofs <= OFS_ALIAS_LAST;
        authen     = (kind != KIND_NONE) && blk_ofs >= OFS_AUTH_FIRST &&
                     blk_ofs <= OFS_AUTH_LAST;
        is_read    = (acc.func == FUNC_READ);
        read_value = '0;
        if (acc.func == FUNC_WRITE)
        begin
            if (authen)
                return;
            if (aliased)
            begin
                // set/clear/toggle aliases all land on the block base word
                word = reg_image[base_wa];
                case (alias_op_t'(blk_ofs[3:2]))
                    OP_PLAIN:  word = acc.write_data;
                    OP_SET:    word = word | acc.write_data;
                    OP_CLEAR:  word = word & ~acc.write_data;
                    OP_TOGGLE: word = word ^ acc.write_data;
                endcase
                reg_image[base_wa] = word;
                return;
            end
            if (kind == KIND_ROOT && blk_ofs == OFS_STATUS0)
                return;
            if (kind == KIND_GATE && (blk_ofs == OFS_STATUS0 || blk_ofs == OFS_STATUS1 ||
                                      blk_ofs == OFS_GATE_LPCUR))
                return;
            reg_image[acc.word_address] = acc.write_data;
            return;
        end
        if (aliased)
            read_value = reg_image[base_wa];
        else if (kind == KIND_ROOT && blk_ofs == OFS_STATUS0)
            read_value = '0;
        else if (kind == KIND_GATE && blk_ofs == OFS_STATUS0)
            read_value = reg_image[base_wa] & GATE_ON;
        else if (kind == KIND_GATE && blk_ofs == OFS_STATUS1)
            read_value = STATUS1_VALUE;
        else if (authen)
            read_value = AUTHEN_VALUE;
        else
            read_value = reg_image[acc.word_address];
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: one transaction offered at a time, held until taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        access_t next_item;
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.func         <= FUNC_READ;
            req_ch.word_address <= '0;
            req_ch.write_data   <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= req_idle_pct)
            begin
                next_item           = pending_items.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.func         <= next_item.func;
                req_ch.word_address <= next_item.word_address;
                req_ch.write_data   <= next_item.write_data;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response ready: random stalls, plus a long hold-off when asked for
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
            holds_done   <= 0;
        end
        else if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (holds_done != holds_asked)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_done   <= holds_done + 1;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check responses against the oldest expected read, then
    // predict the transaction taken at this edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        read_expect_t      exp_read;
        access_t           taken;
        bit                is_read;
        logic [DATA_W-1:0] read_value;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_reads.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected response read_data=%08h",
                                 $realtime, rsp_ch.read_data);
                    mismatch_count++;
                end
                else
                begin
                    exp_read = pending_reads.pop_front();
                    if (rsp_ch.read_data !== exp_read.read_data)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: read of word %04h: expected %08h, got %08h",
                                     $realtime, exp_read.word_address,
                                     exp_read.read_data, rsp_ch.read_data);
                        mismatch_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                taken = '{func: req_ch.func, word_address: req_ch.word_address,
                          write_data: req_ch.write_data};
                apply_access(taken, is_read, read_value);
                if (is_read)
                    pending_reads.push_back('{word_address: taken.word_address,
                                              read_data: read_value});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no transaction on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d reads outstanding",
                     $realtime, pending_reads.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Pick a block index: mostly the first two, sometimes the last
    function automatic int pick_block(input int count);
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return 1;
            default: return count - 1;
        endcase
    endfunction

    // Addresses gather on a few blocks of each window so reads hit earlier writes
    function automatic logic [WA_W-1:0] random_word_address();
        case ($urandom_range(0, 9))
            0, 1, 2:
                return WA_W'(pick_block(ROOT_BLOCKS) * 32 +
                             ($urandom_range(0, 9) < 7 ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 31)));
            3, 4:
                return ($urandom_range(0, 1) ? GPR1_WORD : GPR0_WORD) +
                       WA_W'(pick_block(GPR_BLOCKS) * 16 + $urandom_range(0, 15));
            5, 6:
                if ($urandom_range(0, 1))
                    return GATE0_WORD + WA_W'(pick_block(GATE0_BLOCKS) * 16 +
                                              $urandom_range(0, 15));
                else
                    return GATE1_WORD + WA_W'(pick_block(GATE1_BLOCKS) * 16 +
                                              $urandom_range(0, 15));
            7:
                // gaps between windows and the space past the last gate window
                case ($urandom_range(0, 2))
                    0:       return 14'h0be0 + WA_W'($urandom_range(0, 31));
                    1:       return 14'h27f0 + WA_W'($urandom_range(0, 15));
                    default: return 14'h3000 + WA_W'($urandom_range(0, 31));
                endcase
            default:
                return WA_W'($urandom_range(0, REG_WORDS - 1));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_write_data();
        case ($urandom_range(0, 4))
            0:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            1:       return ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_access(input logic func, input logic [WA_W-1:0] wa,
                                input logic [DATA_W-1:0] data);
        pending_items.push_back('{func: func, word_address: wa, write_data: data});
    endtask

    // Wait until the driver has nothing left and every read has answered;
    // sampled mid-cycle so the driver's edge updates have settled
    task automatic wait_all_done();
        while (pending_items.size() != 0 || req_ch.valid || pending_reads.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        req_idle_pct   = 0;
        rsp_idle_pct   = 0;
        holds_asked    = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        load_power_up_image();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    req_idle_pct = 36;
                    rsp_idle_pct = 67;
                end
                1:
                begin
                    req_idle_pct = 67;
                    rsp_idle_pct = 36;
                end
                default:
                begin
                    req_idle_pct = 0;
                    rsp_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                // Root block 0: each alias kind on the control word
                queue_access(FUNC_READ,  14'h0000, 32'h0000_0000);
                queue_access(FUNC_WRITE, 14'h0000, 32'hffff_ffff);
                queue_access(FUNC_WRITE, 14'h0002, 32'h0000_ffff);  // clear
                queue_access(FUNC_WRITE, 14'h0001, 32'h0000_0001);  // set
                queue_access(FUNC_WRITE, 14'h0003, 32'h8000_0000);  // toggle
                queue_access(FUNC_READ,  14'h0003, 32'h0000_0000);  // alias read-back
                // Root status ignores writes and reads zero
                queue_access(FUNC_WRITE, 14'h0008, 32'h1234_5678);
                queue_access(FUNC_READ,  14'h0008, 32'h0000_0000);
                // Authentication word of a root block
                queue_access(FUNC_WRITE, 14'h000d, 32'ha5a5_a5a5);
                queue_access(FUNC_READ,  14'h000d, 32'h0000_0000);
                // General-purpose blocks in both windows
                queue_access(FUNC_WRITE, GPR0_WORD + 14'd1, 32'h0000_00f0);
                queue_access(FUNC_WRITE, GPR1_WORD + 14'd3, 32'hffff_ffff);
                queue_access(FUNC_READ,  GPR1_WORD,         32'h0000_0000);
                queue_access(FUNC_READ,  GPR0_WORD + 14'd12, 32'h0000_0000);
                // Gate: status0 follows direct bit 0, status1, low-power word
                queue_access(FUNC_READ,  GATE0_WORD + 14'd8, 32'h0000_0000);
                queue_access(FUNC_WRITE, GATE0_WORD,         32'hffff_fffe);
                queue_access(FUNC_READ,  GATE0_WORD + 14'd8, 32'h0000_0000);
                queue_access(FUNC_WRITE, GATE0_WORD + 14'd9, 32'h0000_0000);
                queue_access(FUNC_READ,  GATE0_WORD + 14'd9, 32'h0000_0000);
                queue_access(FUNC_WRITE, GATE0_WORD + 14'd7, 32'hdead_beef);
                queue_access(FUNC_READ,  GATE0_WORD + 14'd7, 32'h0000_0000);
                // Last gate block, then unmapped space with an authen-like offset
                queue_access(FUNC_READ,  14'h27ec, 32'h0000_0000);
                queue_access(FUNC_WRITE, 14'h27fc, 32'hcafe_f00d);
                queue_access(FUNC_READ,  14'h27fc, 32'h0000_0000);
                // Top word of the store
                queue_access(FUNC_WRITE, 14'h3fff, 32'hffff_ffff);
                queue_access(FUNC_READ,  14'h3fff, 32'h0000_0000);
            end

            // Long response hold while the sender keeps offering
            if (phase != 1)
                holds_asked = holds_asked + 1;

            for (int n = 0; n < RANDOM_ITEMS; n++)
                queue_access(logic'($urandom_range(0, 1)), random_word_address(),
                             random_write_data());

            // Sender pauses here until every read of the phase has answered
            wait_all_done();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_reads.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d reads outstanding",
                     mismatch_count, pending_reads.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ccrf_pkg.sv
design/ccrf_if.sv
design/clock_control_register_file.sv
tb/tb.sv
